### src/assert_macros.svh
// Assertion macros shared by the RTL of the evaluation order sorter.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define GEOS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Checks that a cause implies a consequence in the same cycle.
`define GEOS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that a cause implies a consequence in the next cycle.
`define GEOS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### src/geos_pkg.sv
// Package of the evaluation order sorter: sizes, function and status codes, states.
// Depends on nothing; used by the top level and the testbench.
`timescale 1ns / 1ps

package geos_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxEdges = 256;
  localparam int unsigned IdW      = 32;

  typedef enum logic [1:0] {
    FUNC_ADD     = 2'd0,
    FUNC_CONNECT = 2'd1,
    FUNC_COMPILE = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_ZERO_ID   = 3'd1,
    STAT_DUP_ID    = 3'd2,
    STAT_NODE_FULL = 3'd3,
    STAT_MISSING   = 3'd4,
    STAT_EDGE_FULL = 3'd5,
    STAT_EMPTY     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_EMIT,
    ST_INIT,
    ST_EDGE_RD,
    ST_EDGE_CHK,
    ST_EDGE_UPD,
    ST_PICK,
    ST_TAKE,
    ST_FLUSH_RD,
    ST_FLUSH_CHK
  } state_e;

endpackage

### src/geos_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module geos_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/graph_evaluation_order_sort_top.sv
// Top level of the evaluation order sorter; uses geos_pkg, geos_ram and assert_macros.svh.
// Holds the node, edge and work memories and the sequencer that runs them.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The block takes one word at a time and is not ready again until every result word of
// it has been loaded into the output register. Add node and connect scan the node memory
// one slot a cycle. Compile clears the work memory, counts indegrees over the edge memory,
// then per emitted node scans all n slots and walks the edge memory again. If a cycle
// blocks the sort, the remaining nodes go out in two passes. Result words are held in an
// output register, so a stalled consumer only pauses the sequencer.
module graph_evaluation_order_sort_top #(
  parameter int unsigned MAX_NODES = geos_pkg::MaxNodes,
  parameter int unsigned MAX_EDGES = geos_pkg::MaxEdges
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     func_i,
  input  logic [geos_pkg::IdW-1:0]       node_id_i,
  input  logic                           node_is_output_i,
  input  logic [geos_pkg::IdW-1:0]       src_id_i,
  input  logic [geos_pkg::IdW-1:0]       dst_id_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [2:0]                     status_o,
  output logic [$clog2(MAX_NODES)-1:0]   order_slot_o,
  output logic [$clog2(MAX_NODES+1)-1:0] first_output_slot_o,
  output logic                           last_o
);

  import geos_pkg::*;

  localparam int unsigned SW  = $clog2(MAX_NODES);
  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned DW  = ECW;

  state_e state_q, state_d;
  func_e  func_q, func_d;
  status_e status_q, status_d;
  logic [IdW-1:0] key_a_q, key_a_d, key_b_q, key_b_d;
  logic is_out_q, is_out_d;
  logic [CW-1:0] node_total_q, node_total_d;
  logic [ECW-1:0] edge_total_q, edge_total_d;
  logic [CW-1:0] fos_q, fos_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] count_q, count_d;
  logic [ECW-1:0] e_q, e_d;
  logic pend_q, pend_d;
  logic [SW-1:0] pidx_q, pidx_d;
  logic found_a_q, found_a_d, found_b_q, found_b_d;
  logic [SW-1:0] slot_a_q, slot_a_d, slot_b_q, slot_b_d;
  logic have_q, have_d, haveo_q, haveo_d;
  logic [SW-1:0] pick_q, pick_d, picko_q, picko_d, sel_q, sel_d;
  logic mode_q, mode_d, pass_q, pass_d;
  logic out_valid_q, out_valid_d;
  status_e out_status_q, out_status_d;
  logic [SW-1:0] out_slot_q, out_slot_d;
  logic [CW-1:0] out_fos_q, out_fos_d;
  logic out_last_q, out_last_d;

  logic n_we, n_re;
  logic [SW-1:0] n_raddr;
  logic [IdW:0] n_rdata;
  logic e_we, e_re;
  logic [2*SW-1:0] e_rdata;
  logic w_we, w_re;
  logic [SW-1:0] w_waddr, w_raddr;
  logic [DW:0] w_wdata, w_rdata;

  logic out_free, scan_done, cnt_last, e_last, last_c, edge_hit, elig, any_pick, accept;
  logic [SW-1:0] es, ed;

  assign accept    = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign scan_done = (cnt_q >= node_total_q) && !pend_q;
  assign cnt_last  = CW'(cnt_q + 1'b1) == node_total_q;
  assign e_last    = ECW'(e_q + 1'b1) == edge_total_q;
  assign last_c    = CW'(count_q + 1'b1) == node_total_q;
  assign es        = e_rdata[2*SW-1:SW];
  assign ed        = e_rdata[SW-1:0];
  assign edge_hit  = mode_q ? (es == sel_q) : (es != ed);
  assign elig      = !w_rdata[DW] && (n_rdata[IdW] == pass_q);
  assign any_pick  = have_q || haveo_q;

  geos_ram #(.Width(IdW + 1), .Depth(MAX_NODES)) u_node_ram (
    .clk_i, .we_i(n_we), .waddr_i(node_total_q[SW-1:0]), .wdata_i({is_out_q, key_a_q}),
    .re_i(n_re), .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  geos_ram #(.Width(2 * SW), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(edge_total_q[EAW-1:0]), .wdata_i({slot_a_q, slot_b_q}),
    .re_i(e_re), .raddr_i(e_q[EAW-1:0]), .rdata_o(e_rdata)
  );

  geos_ram #(.Width(DW + 1), .Depth(MAX_NODES)) u_work_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .re_i(w_re), .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (func_e'(func_i))
            FUNC_ADD:     state_d = (node_id_i == '0) ? ST_EMIT : ST_LOOKUP;
            FUNC_CONNECT: state_d = ST_LOOKUP;
            FUNC_CLEAR:   state_d = ST_EMIT;
            FUNC_COMPILE: state_d = (node_total_q == '0) ? ST_EMIT : ST_INIT;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: if (scan_done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_EMIT;
      ST_EMIT:   if (out_free) state_d = ST_IDLE;
      ST_INIT: begin
        if (cnt_last) state_d = (edge_total_q == '0) ? ST_PICK : ST_EDGE_RD;
      end
      ST_EDGE_RD: state_d = ST_EDGE_CHK;
      ST_EDGE_CHK: begin
        if (edge_hit) state_d = ST_EDGE_UPD;
        else state_d = e_last ? ST_PICK : ST_EDGE_RD;
      end
      ST_EDGE_UPD: state_d = e_last ? ST_PICK : ST_EDGE_RD;
      ST_PICK:     if (scan_done) state_d = ST_TAKE;
      ST_TAKE: begin
        if (!any_pick) begin
          state_d = ST_FLUSH_RD;
        end else if (out_free) begin
          if (last_c) state_d = ST_IDLE;
          else state_d = (edge_total_q == '0) ? ST_PICK : ST_EDGE_RD;
        end
      end
      ST_FLUSH_RD: state_d = ST_FLUSH_CHK;
      ST_FLUSH_CHK: begin
        if (!(elig && !out_free)) begin
          if (cnt_last && pass_q) state_d = ST_IDLE;
          else state_d = ST_FLUSH_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    func_d = func_q;  status_d = status_q;  key_a_d = key_a_q;  key_b_d = key_b_q;
    is_out_d = is_out_q;  node_total_d = node_total_q;  edge_total_d = edge_total_q;
    fos_d = fos_q;  cnt_d = cnt_q;  count_d = count_q;  e_d = e_q;  pend_d = pend_q;
    pidx_d = pidx_q;  found_a_d = found_a_q;  found_b_d = found_b_q;
    slot_a_d = slot_a_q;  slot_b_d = slot_b_q;  have_d = have_q;  haveo_d = haveo_q;
    pick_d = pick_q;  picko_d = picko_q;  sel_d = sel_q;  mode_d = mode_q;
    pass_d = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;  out_slot_d = out_slot_q;
    out_fos_d = out_fos_q;  out_last_d = out_last_q;
    n_we = 1'b0;  n_re = 1'b0;  n_raddr = cnt_q[SW-1:0];
    e_we = 1'b0;  e_re = 1'b0;
    w_we = 1'b0;  w_re = 1'b0;  w_waddr = cnt_q[SW-1:0];  w_raddr = cnt_q[SW-1:0];
    w_wdata = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d    = func_e'(func_i);
          key_a_d   = (func_e'(func_i) == FUNC_ADD) ? node_id_i : src_id_i;
          key_b_d   = dst_id_i;
          is_out_d  = node_is_output_i;
          cnt_d     = '0;
          count_d   = '0;
          pend_d    = 1'b0;
          found_a_d = 1'b0;
          found_b_d = 1'b0;
          status_d  = STAT_OK;
          unique case (func_e'(func_i))
            FUNC_ADD:     if (node_id_i == '0) status_d = STAT_ZERO_ID;
            FUNC_COMPILE: if (node_total_q == '0) status_d = STAT_EMPTY;
            FUNC_CLEAR: begin
              node_total_d = '0;
              edge_total_d = '0;
              fos_d        = CW'(MAX_NODES);
            end
            default: status_d = STAT_OK;
          endcase
        end
      end
      ST_LOOKUP, ST_PICK: begin
        n_re   = cnt_q < node_total_q;
        w_re   = (state_q == ST_PICK) && (cnt_q < node_total_q);
        pend_d = cnt_q < node_total_q;
        pidx_d = cnt_q[SW-1:0];
        if (cnt_q < node_total_q) cnt_d = CW'(cnt_q + 1'b1);
        if (pend_q && state_q == ST_LOOKUP) begin
          if (!found_a_q && n_rdata[IdW-1:0] == key_a_q) begin
            found_a_d = 1'b1;
            slot_a_d  = pidx_q;
          end
          if (!found_b_q && n_rdata[IdW-1:0] == key_b_q) begin
            found_b_d = 1'b1;
            slot_b_d  = pidx_q;
          end
        end
        if (pend_q && state_q == ST_PICK && !w_rdata[DW] && w_rdata[DW-1:0] == '0) begin
          if (n_rdata[IdW]) begin
            if (!haveo_q) begin
              haveo_d = 1'b1;
              picko_d = pidx_q;
            end
          end else if (!have_q) begin
            have_d = 1'b1;
            pick_d = pidx_q;
          end
        end
      end
      ST_DECIDE: begin
        if (func_q == FUNC_ADD) begin
          if (found_a_q) begin
            status_d = STAT_DUP_ID;
          end else if (node_total_q == CW'(MAX_NODES)) begin
            status_d = STAT_NODE_FULL;
          end else begin
            n_we         = 1'b1;
            node_total_d = CW'(node_total_q + 1'b1);
            if (is_out_q && fos_q == CW'(MAX_NODES)) fos_d = node_total_q;
          end
        end else begin
          if (!found_a_q || !found_b_q) begin
            status_d = STAT_MISSING;
          end else if (edge_total_q == ECW'(MAX_EDGES)) begin
            status_d = STAT_EDGE_FULL;
          end else begin
            e_we         = 1'b1;
            edge_total_d = ECW'(edge_total_q + 1'b1);
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_slot_d   = '0;
          out_fos_d    = fos_q;
          out_last_d   = 1'b1;
        end
      end
      ST_INIT: begin
        w_we    = 1'b1;
        w_wdata = '0;
        cnt_d   = CW'(cnt_q + 1'b1);
        e_d     = '0;
        mode_d  = 1'b0;
      end
      ST_EDGE_RD: e_re = 1'b1;
      ST_EDGE_CHK: begin
        if (edge_hit) begin
          w_re    = 1'b1;
          w_raddr = ed;
        end else begin
          e_d = ECW'(e_q + 1'b1);
        end
      end
      ST_EDGE_UPD: begin
        w_waddr = ed;
        e_d     = ECW'(e_q + 1'b1);
        if (!mode_q) begin
          w_we    = 1'b1;
          w_wdata = {1'b0, DW'(w_rdata[DW-1:0] + 1'b1)};
        end else if (w_rdata[DW-1:0] != '0) begin
          w_we    = 1'b1;
          w_wdata = {w_rdata[DW], DW'(w_rdata[DW-1:0] - 1'b1)};
        end
      end
      ST_TAKE: begin
        if (!any_pick) begin
          cnt_d  = '0;
          pass_d = 1'b0;
        end else if (out_free) begin
          sel_d        = have_q ? pick_q : picko_q;
          w_we         = 1'b1;
          w_waddr      = have_q ? pick_q : picko_q;
          w_wdata      = {1'b1, {DW{1'b0}}};
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_slot_d   = have_q ? pick_q : picko_q;
          out_fos_d    = fos_q;
          out_last_d   = last_c;
          count_d      = CW'(count_q + 1'b1);
          e_d          = '0;
          mode_d       = 1'b1;
        end
      end
      ST_FLUSH_RD: begin
        n_re = 1'b1;
        w_re = 1'b1;
      end
      ST_FLUSH_CHK: begin
        if (elig && out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_slot_d   = cnt_q[SW-1:0];
          out_fos_d    = fos_q;
          out_last_d   = last_c;
          count_d      = CW'(count_q + 1'b1);
        end
        if (!(elig && !out_free)) begin
          if (cnt_last) begin
            cnt_d  = '0;
            pass_d = 1'b1;
          end else begin
            cnt_d = CW'(cnt_q + 1'b1);
          end
        end
      end
      default: pend_d = 1'b0;
    endcase

    if (state_d == ST_PICK && state_q != ST_PICK) begin
      cnt_d   = '0;
      pend_d  = 1'b0;
      have_d  = 1'b0;
      haveo_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_total_q <= '0;
      edge_total_q <= '0;
      fos_q        <= CW'(MAX_NODES);
      out_valid_q  <= 1'b0;
      pend_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_total_q <= node_total_d;
      edge_total_q <= edge_total_d;
      fos_q        <= fos_d;
      out_valid_q  <= out_valid_d;
      pend_q       <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;  status_q <= status_d;  key_a_q <= key_a_d;  key_b_q <= key_b_d;
    is_out_q <= is_out_d;  cnt_q <= cnt_d;  count_q <= count_d;  e_q <= e_d;
    pidx_q <= pidx_d;  found_a_q <= found_a_d;  found_b_q <= found_b_d;
    slot_a_q <= slot_a_d;  slot_b_q <= slot_b_d;  have_q <= have_d;  haveo_q <= haveo_d;
    pick_q <= pick_d;  picko_q <= picko_d;  sel_q <= sel_d;  mode_q <= mode_d;
    pass_q <= pass_d;  out_status_q <= out_status_d;  out_slot_q <= out_slot_d;
    out_fos_q <= out_fos_d;  out_last_q <= out_last_d;
  end

  assign in_ready_o          = state_q == ST_IDLE;
  assign out_valid_o         = out_valid_q;
  assign status_o            = out_status_q;
  assign order_slot_o        = out_slot_q;
  assign first_output_slot_o = out_fos_q;
  assign last_o              = out_last_q;

  `GEOS_ASSERT_ALWAYS(a_node_total_range, node_total_q <= CW'(MAX_NODES))
  `GEOS_ASSERT_ALWAYS(a_fos_consistent, fos_q == CW'(MAX_NODES) || fos_q < node_total_q)
  `GEOS_ASSERT_IMPL(a_take_count, state_q == ST_TAKE, count_q < node_total_q)
  `GEOS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o)

endmodule

### tb/testbench.sv
// Self-checking testbench for graph_evaluation_order_sort_top: a directed table, a full-table
// phase and random graph sequences, checked against an in-bench topological sorter except
// typed table rows, which carry their own expectations. Depends on geos_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
  import geos_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned RandomItems = 130;
  localparam int unsigned FillEdges = 40;

  typedef struct packed {
    status_e    status;
    logic [5:0] slot;
    logic [6:0] fos;
    logic       last;
  } result_t;

  typedef struct {
    func_e       fn;
    logic [31:0] id;
    logic        is_out;
    logic [31:0] src;
    logic [31:0] dst;
    bit          typed;
    status_e     st;
    logic [6:0]  fos;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  func_i = FUNC_ADD;
  logic [31:0] node_id_i = '0;
  logic        node_is_output_i = 1'b0;
  logic [31:0] src_id_i = '0;
  logic [31:0] dst_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [5:0]  order_slot_o;
  logic [6:0]  first_output_slot_o;
  logic        last_o;

  graph_evaluation_order_sort_top dut (.*);

  always #10 clk_i = ~clk_i;

  // Shadow copy of the node and edge tables.
  logic [31:0] node_tab [MaxNodes];
  logic        out_tab  [MaxNodes];
  int unsigned node_cnt;
  logic [5:0]  edge_src [MaxEdges];
  logic [5:0]  edge_dst [MaxEdges];
  int unsigned edge_cnt;

  result_t     order_q [$];
  result_t     pend_q  [$];
  int unsigned errors;
  int unsigned cycles;
  bit          calm;
  int unsigned stall_left;

  function automatic int find_slot(logic [31:0] id);
    for (int i = 0; i < node_cnt; i++) begin
      if (node_tab[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic logic [6:0] lowest_out();
    for (int i = 0; i < node_cnt; i++) begin
      if (out_tab[i]) return 7'(i);
    end
    return 7'(MaxNodes);
  endfunction

  function automatic void push_res(status_e st, int slot, logic [6:0] fos, bit last);
    result_t r;
    r.status = st;
    r.slot = 6'(slot);
    r.fos = fos;
    r.last = last;
    pend_q.push_back(r);
  endfunction

  // Computes the words caused by one command and applies it to the shadow tables.
  function automatic void sort_predict(func_e fn, logic [31:0] id, logic is_out,
                                       logic [31:0] src, logic [31:0] dst);
    int s;
    int d;
    int pick;
    int pick_out;
    int n;
    int indeg [MaxNodes];
    bit taken [MaxNodes];
    logic [6:0] fos;
    status_e st;
    pend_q.delete();
    st = STAT_OK;
    case (fn)
      FUNC_ADD: begin
        if (id == 0) st = STAT_ZERO_ID;
        else if (find_slot(id) >= 0) st = STAT_DUP_ID;
        else if (node_cnt >= MaxNodes) st = STAT_NODE_FULL;
        else begin
          node_tab[node_cnt] = id;
          out_tab[node_cnt] = is_out;
          node_cnt++;
        end
        push_res(st, 0, lowest_out(), 1);
      end
      FUNC_CONNECT: begin
        s = find_slot(src);
        d = find_slot(dst);
        if (s < 0 || d < 0) st = STAT_MISSING;
        else if (edge_cnt >= MaxEdges) st = STAT_EDGE_FULL;
        else begin
          edge_src[edge_cnt] = 6'(s);
          edge_dst[edge_cnt] = 6'(d);
          edge_cnt++;
        end
        push_res(st, 0, lowest_out(), 1);
      end
      FUNC_CLEAR: begin
        node_cnt = 0;
        edge_cnt = 0;
        push_res(STAT_OK, 0, 7'(MaxNodes), 1);
      end
      default: begin
        fos = lowest_out();
        n = node_cnt;
        if (n == 0) begin
          push_res(STAT_EMPTY, 0, fos, 1);
        end else begin
          for (int i = 0; i < n; i++) begin
            indeg[i] = 0;
            taken[i] = 0;
          end
          for (int e = 0; e < edge_cnt; e++) begin
            if (edge_src[e] != edge_dst[e]) indeg[edge_dst[e]]++;
          end
          while (pend_q.size() < n) begin
            pick = -1;
            pick_out = -1;
            for (int i = 0; i < n; i++) begin
              if (!taken[i] && indeg[i] == 0) begin
                if (out_tab[i]) begin
                  if (pick_out < 0) pick_out = i;
                end else if (pick < 0) begin
                  pick = i;
                end
              end
            end
            if (pick < 0) pick = pick_out;
            if (pick < 0) begin
              for (int p = 0; p < 2; p++) begin
                for (int i = 0; i < n; i++) begin
                  if (!taken[i] && out_tab[i] == p) begin
                    taken[i] = 1;
                    push_res(STAT_OK, i, fos, 0);
                  end
                end
              end
              break;
            end
            taken[pick] = 1;
            push_res(STAT_OK, pick, fos, 0);
            for (int e = 0; e < edge_cnt; e++) begin
              if (edge_src[e] == pick && indeg[edge_dst[e]] > 0) indeg[edge_dst[e]]--;
            end
          end
          pend_q[pend_q.size()-1].last = 1;
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Presents one word, waits for it to be accepted and queues what it should produce.
  task automatic send_word(func_e fn, logic [31:0] id, logic is_out, logic [31:0] src,
                           logic [31:0] dst, bit typed = 0, status_e st = STAT_OK,
                           logic [6:0] fos = '0);
    int unsigned gap;
    result_t r;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    node_id_i <= id;
    node_is_output_i <= is_out;
    src_id_i <= src;
    dst_id_i <= dst;
    do @(posedge clk_i); while (!in_ready_o);
    sort_predict(fn, id, is_out, src, dst);
    if (typed) begin
      r.status = st;
      r.slot = '0;
      r.fos = fos;
      r.last = 1'b1;
      order_q.push_back(r);
    end else begin
      foreach (pend_q[i]) order_q.push_back(pend_q[i]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] known_id();
    if (node_cnt == 0 || $urandom_range(0, 9) == 0) return $urandom;
    return node_tab[$urandom_range(0, node_cnt - 1)];
  endfunction

  function automatic logic [31:0] fresh_id();
    logic [31:0] v;
    do v = $urandom; while (v == 0 || find_slot(v) >= 0);
    return v;
  endfunction

  row_t dir_rows [24] = '{
    '{FUNC_COMPILE, 32'h0, 1'b0, 32'h0, 32'h0, 1, STAT_EMPTY, 7'd64},
    '{FUNC_ADD, 32'h0, 1'b1, 32'h0, 32'h0, 1, STAT_ZERO_ID, 7'd64},
    '{FUNC_ADD, 32'hFFFF_FFFF, 1'b1, 32'h0, 32'h0, 1, STAT_OK, 7'd0},
    '{FUNC_ADD, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1, STAT_DUP_ID, 7'd0},
    '{FUNC_ADD, 32'h1, 1'b0, 32'h0, 32'h0, 1, STAT_OK, 7'd0},
    '{FUNC_ADD, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1, STAT_OK, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h5, 32'h1, 1, STAT_MISSING, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h1, 32'h0, 1, STAT_MISSING, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h1, 32'h8000_0000, 0, STAT_OK, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 0, STAT_OK, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h1, 32'h1, 0, STAT_OK, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h1, 32'h8000_0000, 0, STAT_OK, 7'd0},
    '{FUNC_COMPILE, 32'h0, 1'b0, 32'h0, 32'h0, 0, STAT_OK, 7'd0},
    '{FUNC_ADD, 32'h2, 1'b1, 32'h0, 32'h0, 0, STAT_OK, 7'd0},
    '{FUNC_ADD, 32'h3, 1'b0, 32'h0, 32'h0, 0, STAT_OK, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h2, 32'h3, 0, STAT_OK, 7'd0},
    '{FUNC_CONNECT, 32'h0, 1'b0, 32'h3, 32'h2, 0, STAT_OK, 7'd0},
    '{FUNC_COMPILE, 32'h0, 1'b0, 32'h0, 32'h0, 0, STAT_OK, 7'd0},
    '{FUNC_CLEAR, 32'h0, 1'b0, 32'h0, 32'h0, 1, STAT_OK, 7'd64},
    '{FUNC_COMPILE, 32'h0, 1'b0, 32'h0, 32'h0, 1, STAT_EMPTY, 7'd64},
    '{FUNC_ADD, 32'h7, 1'b1, 32'h0, 32'h0, 1, STAT_OK, 7'd0},
    '{FUNC_ADD, 32'h8, 1'b1, 32'h0, 32'h0, 1, STAT_OK, 7'd0},
    '{FUNC_COMPILE, 32'h0, 1'b0, 32'h0, 32'h0, 0, STAT_OK, 7'd0},
    '{FUNC_CLEAR, 32'h0, 1'b0, 32'h0, 32'h0, 1, STAT_OK, 7'd64}
  };

  // Consumer side: checks each delivered word and stalls in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (out_valid_o && out_ready_i) begin
        if (order_q.size() == 0) begin
          report_mismatch("unexpected word, status", status_o, 0);
        end else begin
          if (status_o != order_q[0].status)
            report_mismatch("status", status_o, order_q[0].status);
          if (order_slot_o != order_q[0].slot)
            report_mismatch("order_slot", order_slot_o, order_q[0].slot);
          if (first_output_slot_o != order_q[0].fos)
            report_mismatch("first_output_slot", first_output_slot_o, order_q[0].fos);
          if (last_o != order_q[0].last) report_mismatch("last", last_o, order_q[0].last);
          void'(order_q.pop_front());
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
      if (cycles > CycleLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned k;
    errors = 0;
    cycles = 0;
    calm = 0;
    stall_left = 0;
    node_cnt = 0;
    edge_cnt = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].fn, dir_rows[i].id, dir_rows[i].is_out, dir_rows[i].src,
                dir_rows[i].dst, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].fos);
    end

    // Fill the node table past its limit, connect part of it, then sort the largest graph.
    drain();
    for (int i = 0; i < MaxNodes + 1; i++) begin
      send_word(FUNC_ADD, fresh_id(), $urandom_range(0, 3) == 0, '0, '0);
    end
    for (int i = 0; i < FillEdges; i++) begin
      send_word(FUNC_CONNECT, '0, 1'b0, node_tab[$urandom_range(0, MaxNodes - 1)],
                node_tab[$urandom_range(0, MaxNodes - 1)]);
    end
    send_word(FUNC_COMPILE, $urandom, 1'($urandom), $urandom, $urandom);
    send_word(FUNC_CLEAR, $urandom, 1'($urandom), $urandom, $urandom);

    sent = 0;
    while (sent < RandomItems) begin
      if (sent > RandomItems * 4 / 5) calm = 1;
      if ($urandom_range(0, 5) == 0) drain();
      if ($urandom_range(0, 9) < 8) begin
        if (node_cnt > 20 || edge_cnt > 60 || $urandom_range(0, 2) == 0) begin
          send_word(FUNC_CLEAR, $urandom, 1'($urandom), $urandom, $urandom);
          sent++;
        end
        k = $urandom_range(1, 8);
        repeat (k) begin
          case ($urandom_range(0, 9))
            0: send_word(FUNC_ADD, '0, 1'($urandom), $urandom, $urandom);
            1: send_word(FUNC_ADD, known_id(), 1'($urandom), $urandom, $urandom);
            default: send_word(FUNC_ADD, fresh_id(), 1'($urandom), $urandom, $urandom);
          endcase
          sent++;
        end
        k = $urandom_range(0, 12);
        repeat (k) begin
          send_word(FUNC_CONNECT, $urandom, 1'($urandom), known_id(), known_id());
          sent++;
        end
        send_word(FUNC_COMPILE, $urandom, 1'($urandom), $urandom, $urandom);
        sent++;
      end else begin
        send_word(func_e'($urandom_range(0, 3)), $urandom_range(0, 1) ? known_id() : $urandom,
                  1'($urandom), known_id(), known_id());
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (order_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/geos_pkg.sv
src/geos_ram.sv
src/graph_evaluation_order_sort_top.sv
tb/testbench.sv
